>>> rtl/ppta_pkg.sv
// Shared types and constants for the preemptive priority token arbiter.
// No dependencies; every other file in rtl/ imports this package.
package ppta_pkg;

  localparam int NUM_CPUS  = 8;
  localparam int CPU_W     = 3;
  localparam int PRIO_W    = $clog2(NUM_CPUS + 1);
  localparam int TIME_W    = 64;
  localparam int S_TDATA_W = 72;
  localparam int M_TDATA_W = 72;

  typedef logic [CPU_W-1:0]  cpu_t;
  typedef logic [PRIO_W-1:0] prio_t;
  typedef logic [TIME_W-1:0] time_t;

  typedef enum logic {
    KIND_REQUEST = 1'b0,
    KIND_REVOKE  = 1'b1
  } kind_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_LAUNCH,
    ST_SCAN,
    ST_DIFF,
    ST_ELAPSED,
    ST_SUM,
    ST_TRIPLE,
    ST_NEXT,
    ST_COMMIT,
    ST_RESP
  } state_e;

  // token that walks the cell chain, gathering per-CPU state
  typedef struct packed {
    logic  valid;
    prio_t best_prio;
    cpu_t  best_idx;
    time_t cpu_start;
    time_t own_start;
    time_t own_acc;
  } tok_t;

  // what the cells look for during a pass
  typedef struct packed {
    kind_e kind;
    cpu_t  cpu;
    cpu_t  owner;
  } key_t;

  // write strobes broadcast to the cells; two start-time ports for revoke
  typedef struct packed {
    logic  req_we;
    cpu_t  req_idx;
    prio_t req_val;
    logic  sa_we;
    cpu_t  sa_idx;
    time_t sa_val;
    logic  sb_we;
    cpu_t  sb_idx;
    time_t sb_val;
    logic  acc_we;
    cpu_t  acc_idx;
    time_t acc_val;
  } wr_t;

  typedef struct packed {
    logic  notify_resume;
    cpu_t  notify_cpu;
    logic  notify_valid;
    time_t wait_ticks;
    logic  ack;
  } res_t;

endpackage

>>> rtl/ppta_cell.sv
// One CPU slot of the arbiter chain: request priority, start/next time, used time.
// Depends on ppta_pkg.
module ppta_cell import ppta_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  cpu_t idx_i,
  input  key_t key_i,
  input  wr_t  wr_i,
  input  tok_t tok_i,
  output tok_t tok_o
);

  prio_t req_q;
  time_t start_q;
  time_t acc_q;
  tok_t  tok_q, tok_d;
  prio_t prio_eff;

  always_comb begin
    // a revoking CPU drops out of its own scan
    prio_eff = ((key_i.kind == KIND_REVOKE) && (key_i.cpu == idx_i)) ? '0 : req_q;
    tok_d       = tok_q;
    tok_d.valid = tok_i.valid;
    if (tok_i.valid) begin
      tok_d = tok_i;
      if (key_i.cpu == idx_i) begin
        tok_d.cpu_start = start_q;
      end
      if (key_i.owner == idx_i) begin
        tok_d.own_start = start_q;
        tok_d.own_acc   = acc_q;
      end
      // strict compare: ties stay with the lower index seen first
      if (prio_eff > tok_i.best_prio) begin
        tok_d.best_prio = prio_eff;
        tok_d.best_idx  = idx_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_q   <= '0;
      req_q   <= '0;
      start_q <= '0;
      acc_q   <= '0;
    end else begin
      tok_q <= tok_d;
      if (wr_i.req_we && (wr_i.req_idx == idx_i)) begin
        req_q <= wr_i.req_val;
      end
      if (wr_i.sa_we && (wr_i.sa_idx == idx_i)) begin
        start_q <= wr_i.sa_val;
      end else if (wr_i.sb_we && (wr_i.sb_idx == idx_i)) begin
        start_q <= wr_i.sb_val;
      end
      if (wr_i.acc_we && (wr_i.acc_idx == idx_i)) begin
        acc_q <= wr_i.acc_val;
      end
    end
  end

  assign tok_o = tok_q;

endmodule

>>> rtl/ppta_ctrl.sv
// Sequencer of the arbiter: item capture, chain launch, time arithmetic,
// owner register, cell write-back and output register. Depends on ppta_pkg.
module ppta_ctrl import ppta_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  input  logic [S_TDATA_W-1:0] s_axis_tdata,
  input  logic                 s_axis_tuser,
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  output logic [M_TDATA_W-1:0] m_axis_tdata,
  input  logic                 cfg_we_i,
  input  logic                 cfg_wdata_i,
  output key_t                 key_o,
  output tok_t                 tok_head_o,
  input  tok_t                 tok_tail_i,
  output wr_t                  wr_o
);

  state_e state_q, state_d;
  logic   wm_q;
  kind_e  kind_q;
  cpu_t   cpu_q;
  prio_t  prio_q;
  time_t  now_q;
  logic   owner_valid_q, owner_valid_d;
  cpu_t   owner_idx_q, owner_idx_d;
  prio_t  owner_prio_q, owner_prio_d;
  logic   refused_q;
  time_t  t0_q, t1_q;
  res_t   res_q, res_d;
  logic   m_valid_q;
  logic [M_TDATA_W-1:0] m_tdata_q;

  logic s_acc, out_load;
  logic [CPU_W-1:0] in_cpu;
  logic [2:0]       in_dec;
  logic grant, preempt, owns, winner;

  assign s_axis_tready = (state_q == ST_IDLE);
  assign s_acc         = s_axis_tvalid && s_axis_tready;
  assign out_load      = (state_q == ST_RESP) && (!m_valid_q || m_axis_tready);
  assign in_cpu        = s_axis_tdata[2:0];
  assign in_dec        = s_axis_tdata[5:3];

  assign key_o = '{kind: kind_q, cpu: cpu_q, owner: owner_idx_q};

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:    if (s_acc) state_d = ST_LAUNCH;
      ST_LAUNCH:  state_d = ST_SCAN;
      ST_SCAN:    if (tok_tail_i.valid) state_d = ST_DIFF;
      ST_DIFF:    state_d = ST_ELAPSED;
      ST_ELAPSED: state_d = ST_SUM;
      ST_SUM:     state_d = (kind_q == KIND_REVOKE) ? ST_TRIPLE : ST_COMMIT;
      ST_TRIPLE:  state_d = ST_NEXT;
      ST_NEXT:    state_d = ST_COMMIT;
      ST_COMMIT:  state_d = ST_RESP;
      ST_RESP:    if (out_load) state_d = ST_IDLE;
      default:    state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    tok_head_o       = '0;
    tok_head_o.valid = (state_q == ST_LAUNCH);
    wr_o             = '0;
    owner_valid_d    = owner_valid_q;
    owner_idx_d      = owner_idx_q;
    owner_prio_d     = owner_prio_q;
    res_d            = '0;
    grant            = 1'b0;
    preempt          = 1'b0;
    owns             = 1'b0;
    winner           = 1'b0;
    if (state_q == ST_COMMIT) begin
      if (kind_q == KIND_REQUEST) begin
        grant   = !refused_q && (prio_q > owner_prio_q);
        preempt = grant && owner_valid_q && (owner_idx_q != cpu_q);
        wr_o.req_we  = !refused_q;
        wr_o.req_idx = cpu_q;
        wr_o.req_val = prio_q;
        // preempted owner banks its elapsed time (t1 = acc + now - start)
        wr_o.acc_we  = preempt && wm_q;
        wr_o.acc_idx = owner_idx_q;
        wr_o.acc_val = t1_q;
        wr_o.sa_we   = grant && wm_q;
        wr_o.sa_idx  = cpu_q;
        wr_o.sa_val  = now_q;
        if (grant) begin
          owner_valid_d = 1'b1;
          owner_idx_d   = cpu_q;
          owner_prio_d  = prio_q;
        end
        res_d.ack           = !refused_q && (grant || (owner_valid_q && (owner_idx_q == cpu_q)));
        res_d.wait_ticks    = refused_q ? t0_q : '0;
        res_d.notify_valid  = preempt;
        res_d.notify_cpu    = preempt ? owner_idx_q : '0;
        res_d.notify_resume = 1'b0;
      end else begin
        owns   = owner_valid_q && (owner_idx_q == cpu_q);
        winner = owns && (tok_tail_i.best_prio != '0);
        wr_o.req_we  = 1'b1;
        wr_o.req_idx = cpu_q;
        wr_o.req_val = '0;
        // back-off: next allowed time = now + 3 * used, left in t1
        wr_o.sa_we   = owns && wm_q;
        wr_o.sa_idx  = cpu_q;
        wr_o.sa_val  = t1_q;
        wr_o.acc_we  = owns && wm_q;
        wr_o.acc_idx = cpu_q;
        wr_o.acc_val = '0;
        wr_o.sb_we   = winner && wm_q;
        wr_o.sb_idx  = tok_tail_i.best_idx;
        wr_o.sb_val  = now_q;
        if (owns) begin
          owner_valid_d = winner;
          owner_idx_d   = winner ? tok_tail_i.best_idx : '0;
          owner_prio_d  = winner ? tok_tail_i.best_prio : '0;
        end
        res_d.notify_valid  = winner;
        res_d.notify_cpu    = winner ? tok_tail_i.best_idx : '0;
        res_d.notify_resume = winner;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_IDLE;
      wm_q          <= 1'b0;
      owner_valid_q <= 1'b0;
      owner_idx_q   <= '0;
      owner_prio_q  <= '0;
      m_valid_q     <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        wm_q <= cfg_wdata_i;
      end
      if (state_q == ST_COMMIT) begin
        owner_valid_q <= owner_valid_d;
        owner_idx_q   <= owner_idx_d;
        owner_prio_q  <= owner_prio_d;
      end
      m_valid_q <= (m_valid_q && !m_axis_tready) || out_load;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_acc) begin
      kind_q <= kind_e'(s_axis_tuser);
      cpu_q  <= in_cpu;
      prio_q <= (int'(in_dec) >= NUM_CPUS) ? '0 : PRIO_W'(NUM_CPUS - int'(in_dec));
      now_q  <= s_axis_tdata[69:6];
    end
    case (state_q)
      ST_DIFF: begin
        refused_q <= wm_q && (now_q < tok_tail_i.cpu_start);
        t0_q      <= tok_tail_i.cpu_start - now_q;
      end
      ST_ELAPSED: t1_q <= now_q - tok_tail_i.own_start;
      ST_SUM:     t1_q <= tok_tail_i.own_acc + t1_q;
      ST_TRIPLE:  t1_q <= t1_q + {t1_q[TIME_W-2:0], 1'b0};
      ST_NEXT:    t1_q <= now_q + t1_q;
      ST_COMMIT:  res_q <= res_d;
      ST_RESP:    if (out_load) m_tdata_q <= {2'b00, res_q};
      default:    ;
    endcase
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_tdata_q;

endmodule

>>> rtl/preemptive_priority_token_arbiter_unit.sv
// channel  | direction | handshake                    | payload
// input    | in        | s_axis_tvalid/s_axis_tready  | tuser kind; tdata cpu_id, urgency, now
// output   | out       | m_axis_tvalid/m_axis_tready  | tdata ack .. notify_resume
// config   | in        | cfg_we_i                     | cfg_wdata_i = wait_mode_enable
//
// One item at a time. A request passes the launch, scan, diff, elapsed, sum and commit
// states, a revoke also triple and next before commit; the scan lasts until the token has
// walked the NUM_CPUS cells. The next item is taken in the cycle after the result register
// is loaded. Reset clears owner, all request priorities, times and the mode bit.
// A stalled output holds the sequencer in its final state; the input is not taken then.
//
// Top level: sequencer plus a chain of NUM_CPUS cells. Depends on ppta_pkg,
// ppta_cell and ppta_ctrl.
module preemptive_priority_token_arbiter_unit import ppta_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  // [2:0] cpu_id, [5:3] urgency, [69:6] now, [71:70] zero
  input  logic [S_TDATA_W-1:0] s_axis_tdata,
  // [0] kind
  input  logic                 s_axis_tuser,
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  // [0] ack, [64:1] wait_ticks, [65] notify_valid, [68:66] notify_cpu,
  // [69] notify_resume, [71:70] zero
  output logic [M_TDATA_W-1:0] m_axis_tdata,
  input  logic                 cfg_we_i,
  input  logic                 cfg_wdata_i
);

  key_t key;
  wr_t  wr;
  tok_t tok [NUM_CPUS+1];

  ppta_ctrl u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .key_o         (key),
    .tok_head_o    (tok[0]),
    .tok_tail_i    (tok[NUM_CPUS]),
    .wr_o          (wr)
  );

  for (genvar i = 0; i < NUM_CPUS; i++) begin : g_cell
    ppta_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .idx_i  (CPU_W'(i)),
      .key_i  (key),
      .wr_i   (wr),
      .tok_i  (tok[i]),
      .tok_o  (tok[i+1])
    );
  end

endmodule

>>> rtl/ppta_checker.sv
// Port-level checks for the arbiter top level, attached by bind.
// Depends on ppta_pkg and preemptive_priority_token_arbiter_unit.
module ppta_checker import ppta_pkg::*; (
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 s_axis_tvalid,
  input logic                 s_axis_tready,
  input logic                 m_axis_tvalid,
  input logic                 m_axis_tready,
  input logic [M_TDATA_W-1:0] m_axis_tdata
);

  // one item in flight: no second accept straight after the first
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("input taken twice in a row");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
    else $error("stalled output item changed");

  // a notice kind without a notice, or an ack together with a back-off
  a_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> ((!m_axis_tdata[69] || m_axis_tdata[65]) &&
                       (!m_axis_tdata[0] || (m_axis_tdata[64:1] == '0))))
    else $error("inconsistent result fields");

  // a pause notice only comes with a granted request
  a_pause_ack: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tdata[65] && !m_axis_tdata[69]) |-> m_axis_tdata[0])
    else $error("pause notice without grant");

endmodule

bind preemptive_priority_token_arbiter_unit ppta_checker u_ppta_checker (.*);

>>> tb/sv/testbench.sv
// Self-checking testbench for preemptive_priority_token_arbiter_unit.
// A directed table, then phases of random requests and revokes with back-off on and off,
// checked against the table or an owner predictor. Depends on ppta_pkg and the RTL only.
`timescale 1ns / 1ps

module testbench;
  import ppta_pkg::*;

  localparam int STALL_LIMIT    = 4000;
  localparam int RAND_PER_PHASE = 142;
  localparam int N_PHASES       = 6;
  // back-off mode per random phase, phase 0 in bit 0
  localparam bit [N_PHASES-1:0] PHASE_MODE = 6'b101101;
  localparam time_t T_MAX = 64'hFFFF_FFFF_FFFF_FFFF;

  typedef struct packed {
    logic  ack;
    time_t wait_ticks;
    logic  notify_valid;
    cpu_t  notify_cpu;
    logic  notify_resume;
  } grant_t;

  localparam grant_t G_NONE = '0;

  typedef struct {
    bit         cfg;      // register write instead of an item
    bit         cfg_val;
    kind_e      kind;
    cpu_t       cpu;
    logic [2:0] dprio;
    time_t      stamp;
    bit         typed;    // want holds the expected grant, else predicted
    grant_t     want;
  } stim_row_t;

  localparam int N_DIRECTED = 22;
  stim_row_t directed [N_DIRECTED] = '{
    // empty arbiter: lowest priority takes the token
    '{0, 0, KIND_REQUEST, 3'd0, 3'd7, 64'd0, 1, '{1'b1, 64'd0, 1'b0, 3'd0, 1'b0}},
    // equal priority does not preempt
    '{0, 0, KIND_REQUEST, 3'd1, 3'd7, 64'd0, 1, G_NONE},
    // most urgent preempts, pause notice to cpu 0
    '{0, 0, KIND_REQUEST, 3'd2, 3'd0, 64'd0, 1, '{1'b1, 64'd0, 1'b1, 3'd0, 1'b0}},
    '{0, 0, KIND_REQUEST, 3'd2, 3'd3, 64'd0, 0, G_NONE},
    // revoke by a non-owner
    '{0, 0, KIND_REVOKE,  3'd5, 3'd0, 64'd0, 1, G_NONE},
    // owner revokes, tie between cpu 0 and 1 goes to cpu 0
    '{0, 0, KIND_REVOKE,  3'd2, 3'd0, 64'd0, 1, '{1'b0, 64'd0, 1'b1, 3'd0, 1'b1}},
    '{0, 0, KIND_REQUEST, 3'd7, 3'd0, 64'd0, 0, G_NONE},
    '{0, 0, KIND_REVOKE,  3'd7, 3'd7, 64'd0, 0, G_NONE},
    '{0, 0, KIND_REVOKE,  3'd0, 3'd0, 64'd0, 0, G_NONE},
    // last request gone: no resume
    '{0, 0, KIND_REVOKE,  3'd1, 3'd0, 64'd0, 1, G_NONE},
    '{0, 0, KIND_REQUEST, 3'd3, 3'd5, 64'd0, 0, G_NONE},
    // owner raises its own priority
    '{0, 0, KIND_REQUEST, 3'd3, 3'd1, 64'd0, 0, G_NONE},
    '{1, 1, KIND_REQUEST, 3'd0, 3'd0, 64'd0, 0, G_NONE},
    '{0, 0, KIND_REQUEST, 3'd4, 3'd0, 64'd100, 0, G_NONE},
    '{0, 0, KIND_REVOKE,  3'd4, 3'd0, 64'd110, 0, G_NONE},
    // held 10 ticks, so refused until 140
    '{0, 0, KIND_REQUEST, 3'd4, 3'd2, 64'd120, 1, '{1'b0, 64'd20, 1'b0, 3'd0, 1'b0}},
    '{0, 0, KIND_REQUEST, 3'd4, 3'd2, 64'd140, 0, G_NONE},
    '{0, 0, KIND_REVOKE,  3'd3, 3'd0, T_MAX, 0, G_NONE},
    '{0, 0, KIND_REQUEST, 3'd6, 3'd7, T_MAX, 0, G_NONE},
    '{1, 0, KIND_REQUEST, 3'd0, 3'd0, 64'd0, 0, G_NONE},
    // stale back-off ignored while the mode is off
    '{0, 0, KIND_REQUEST, 3'd5, 3'd4, 64'd0, 0, G_NONE},
    '{0, 0, KIND_REVOKE,  3'd4, 3'd7, 64'd5, 0, G_NONE}
  };

  logic                 clk_i         = 1'b0;
  logic                 rst_ni        = 1'b0;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [S_TDATA_W-1:0] s_axis_tdata  = '0;
  logic                 s_axis_tuser  = 1'b0;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [M_TDATA_W-1:0] m_axis_tdata;
  logic                 cfg_we_i      = 1'b0;
  logic                 cfg_wdata_i   = 1'b0;

  // predicted arbiter state
  bit    backoff_on = 1'b0;
  bit    tok_held   = 1'b0;
  cpu_t  tok_owner  = '0;
  prio_t tok_prio   = '0;
  prio_t want_prio [NUM_CPUS] = '{default: '0};
  time_t mark_time [NUM_CPUS] = '{default: '0};
  time_t held_time [NUM_CPUS] = '{default: '0};

  grant_t pending_grants [$];
  int     n_items    = 0;
  int     n_checked  = 0;
  int     n_refused  = 0;
  int     n_notices  = 0;
  int     n_err      = 0;
  bit     send_calm  = 1'b0;
  bit     recv_calm  = 1'b0;

  always #1 clk_i = ~clk_i;

  preemptive_priority_token_arbiter_unit i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i)
  );

  // Advances the predicted state by one item and returns the grant it yields.
  // cpu_id and dec_prio are 3 bits wide, so with 8 CPUs both are always in range.
  function automatic grant_t arbitrate(kind_e k, cpu_t c, logic [2:0] dp, time_t t);
    grant_t r;
    prio_t  p;
    time_t  used;
    r = '0;
    p = prio_t'(NUM_CPUS - dp);
    if (k == KIND_REQUEST) begin
      if (backoff_on && t < mark_time[c]) begin
        r.wait_ticks = mark_time[c] - t;
      end else begin
        want_prio[c] = p;
        if (p > tok_prio) begin
          if (tok_held && tok_owner != c) begin
            r.notify_valid = 1'b1;
            r.notify_cpu   = tok_owner;
            if (backoff_on) held_time[tok_owner] += t - mark_time[tok_owner];
          end
          if (backoff_on) mark_time[c] = t;
          tok_held  = 1'b1;
          tok_owner = c;
          tok_prio  = p;
        end
        r.ack = tok_held && tok_owner == c;
      end
    end else begin
      want_prio[c] = '0;
      if (tok_held && tok_owner == c) begin
        if (backoff_on) begin
          used         = held_time[c] + (t - mark_time[c]);
          mark_time[c] = t + used * 64'd3;
          held_time[c] = '0;
        end
        tok_held  = 1'b0;
        tok_owner = '0;
        tok_prio  = '0;
        // strict compare keeps the lowest index on a tie
        for (int i = 0; i < NUM_CPUS; i++) begin
          if (want_prio[i] > tok_prio) begin
            tok_prio  = want_prio[i];
            tok_owner = cpu_t'(i);
            tok_held  = 1'b1;
          end
        end
        if (tok_held) begin
          r.notify_valid  = 1'b1;
          r.notify_cpu    = tok_owner;
          r.notify_resume = 1'b1;
          if (backoff_on) mark_time[tok_owner] = t;
        end
      end
    end
    return r;
  endfunction

  task automatic push_item(kind_e k, cpu_t c, logic [2:0] dp, time_t t, bit typed,
                           grant_t want);
    int     gap;
    grant_t pred;
    if (n_items % 40 == 0) send_calm = ($urandom_range(0, 3) == 0);
    gap = send_calm ? 0 : $urandom_range(0, 11);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= k;
    s_axis_tdata  <= {2'b00, t, dp, c};
    do @(posedge clk_i); while (!s_axis_tready);
    pred = arbitrate(k, c, dp, t);
    pending_grants.push_back(typed ? want : pred);
    n_items++;
  endtask

  // Every item yields a result, so an empty queue means the arbiter is idle.
  task automatic set_wait_mode(bit v);
    s_axis_tvalid <= 1'b0;
    while (pending_grants.size() != 0) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    backoff_on = v;
  endtask

  task automatic check_field(string fname, logic [63:0] want, logic [63:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, fname, want, got);
      n_err++;
    end
  endtask

  initial begin : collect_grants
    int     stall;
    grant_t got;
    grant_t want;
    do @(posedge clk_i); while (!rst_ni);
    forever begin
      if (n_checked % 30 == 0) recv_calm = ($urandom_range(0, 3) == 0);
      stall = recv_calm ? 0 : $urandom_range(0, 11);
      if (stall > 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid);
      got.ack           = m_axis_tdata[0];
      got.wait_ticks    = m_axis_tdata[64:1];
      got.notify_valid  = m_axis_tdata[65];
      got.notify_cpu    = m_axis_tdata[68:66];
      got.notify_resume = m_axis_tdata[69];
      if (pending_grants.size() == 0) begin
        $display("%0t: result with nothing expected, got %0h", $time, got);
        n_err++;
      end else begin
        want = pending_grants.pop_front();
        check_field("ack", 64'(want.ack), 64'(got.ack));
        check_field("wait_ticks", want.wait_ticks, got.wait_ticks);
        check_field("notify_valid", 64'(want.notify_valid), 64'(got.notify_valid));
        check_field("notify_cpu", 64'(want.notify_cpu), 64'(got.notify_cpu));
        check_field("notify_resume", 64'(want.notify_resume), 64'(got.notify_resume));
      end
      n_checked++;
      if (got.wait_ticks != 0) n_refused++;
      if (got.notify_valid) n_notices++;
    end
  end

  initial begin : watchdog
    int idle_cycles;
    idle_cycles = 0;
    do @(posedge clk_i); while (!rst_ni);
    while (idle_cycles < STALL_LIMIT) begin
      @(posedge clk_i);
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
    end
    $display("%0t: no handshake for %0d cycles, %0d results outstanding",
             $time, STALL_LIMIT, pending_grants.size());
    $display("FAILURE");
    $finish;
  end

  initial begin : stimulus
    time_t      clk_count;
    time_t      stamp;
    kind_e      k;
    cpu_t       c;
    logic [2:0] dp;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed[i]) begin
      if (directed[i].cfg) begin
        set_wait_mode(directed[i].cfg_val);
      end else begin
        push_item(directed[i].kind, directed[i].cpu, directed[i].dprio, directed[i].stamp,
                  directed[i].typed, directed[i].want);
      end
    end

    clk_count = 64'd1000;
    for (int ph = 0; ph < N_PHASES; ph++) begin
      set_wait_mode(PHASE_MODE[ph]);
      // run the timer across the 2^64 wrap in one back-off phase
      if (ph == 3) clk_count = 64'hFFFF_FFFF_FFFF_F800;
      for (int j = 0; j < RAND_PER_PHASE; j++) begin
        clk_count += ($urandom_range(0, 19) == 0) ? $urandom_range(0, 2000)
                                                  : $urandom_range(0, 40);
        stamp = ($urandom_range(0, 9) == 0) ? {$urandom, $urandom} : clk_count;
        k     = ($urandom_range(0, 9) < 4) ? KIND_REVOKE : KIND_REQUEST;
        // revokes mostly come from the owner so that scans and resumes happen often
        if (k == KIND_REVOKE && tok_held && $urandom_range(0, 1)) c = tok_owner;
        else c = cpu_t'($urandom_range(0, NUM_CPUS - 1));
        dp = 3'($urandom_range(0, 7));
        push_item(k, c, dp, stamp, 1'b0, G_NONE);
      end
    end

    s_axis_tvalid <= 1'b0;
    while (pending_grants.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
    if (pending_grants.size() != 0) n_err++;

    // the directed table holds two register writes
    $display("Ran %0d items (%0d directed), back-off toggled over %0d phases, wrap included.",
             n_items, N_DIRECTED - 2, N_PHASES);
    $display("%0d results checked: %0d refused requests, %0d pause or resume notices.",
             n_checked, n_refused, n_notices);
    if (n_err == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
